// File: src/cmh_pkg.sv
// ----------------------------------------------------------------------------
// cmh_pkg
// Shared constants, types and helpers for the chunked Mersenne hash block.
// ----------------------------------------------------------------------------
package cmh_pkg;

    localparam logic [63:0] KTAB [0:15] = '{
        64'h2dd7caaefcf073eb, 64'ha9209937349cfe9c,
        64'hb84bfc934b0e60ef, 64'hff709c157b26e477,
        64'h3936fd8735455112, 64'hca141bf22338d331,
        64'hdd40e749cb64fd02, 64'h5e268f564b0deb26,
        64'h658239596bdea9ec, 64'h31cedf33ac38c624,
        64'h12f56816481b0cfd, 64'h94e9de155f40f095,
        64'h5089c907844c6325, 64'hdf887e97d73c50e3,
        64'hae8870787ce3c11d, 64'ha6767d18c58d2117
    };

    localparam logic [63:0] RC_HI      = 64'he3f0d44988bcdfab;
    localparam logic [63:0] RC_LO      = 64'h081570afdd535ec3;
    localparam logic [63:0] FIN_A      = 64'hce7c4801d683e824;
    localparam logic [63:0] FIN_B      = 64'h6823775b1daad522;
    localparam logic [63:0] SUM_MASK   = 64'h3fffffffffffffff;
    localparam logic [63:0] P127_HI    = 64'h7fffffffffffffff;
    localparam logic [63:0] FOLD       = 64'h0000000000000101;
    localparam logic [63:0] FOLD_LIMIT = 64'hfffffffffffffefe;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  valid_bytes;
        logic        last;
    } cmh_item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] hash;
    } cmh_res_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] nbytes);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = (4'(i) < nbytes) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// File: src/cmh_mul.sv
// ----------------------------------------------------------------------------
// cmh_mul
// Shared 32x32 unsigned multiplier with registered product and column tag.
// ----------------------------------------------------------------------------
module cmh_mul (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    input  logic [2:0]  col,
    output logic        p_valid,
    output logic [63:0] p,
    output logic [2:0]  p_col
);

    logic        valid_reg;
    logic [63:0] prod_reg;
    logic [2:0]  col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= en;
        end
        prod_reg <= 64'(op_a) * 64'(op_b);
        col_reg  <= col;
    end

    assign p_valid = valid_reg;
    assign p       = prod_reg;
    assign p_col   = col_reg;

endmodule

// File: src/cmh_engine.sv
// ----------------------------------------------------------------------------
// cmh_engine
// Sequencer and datapath: pair products, chunk fold and finalization, all
// through one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module cmh_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmh_pkg::cmh_item_t item,
    input  logic              out_free,
    output cmh_pkg::cmh_res_t res
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_PMUL = 5'd1;
    localparam logic [4:0] S_POS  = 5'd2;
    localparam logic [4:0] S_AADD = 5'd3;
    localparam logic [4:0] S_FMUL = 5'd4;
    localparam logic [4:0] S_Q2   = 5'd5;
    localparam logic [4:0] S_Q3   = 5'd6;
    localparam logic [4:0] S_Q0   = 5'd7;
    localparam logic [4:0] S_Q1   = 5'd8;
    localparam logic [4:0] S_QWR  = 5'd9;
    localparam logic [4:0] S_F1   = 5'd10;
    localparam logic [4:0] S_F2   = 5'd11;
    localparam logic [4:0] S_F3   = 5'd12;
    localparam logic [4:0] S_F4   = 5'd13;
    localparam logic [4:0] S_F5   = 5'd14;
    localparam logic [4:0] S_F6   = 5'd15;
    localparam logic [4:0] S_F7   = 5'd16;
    localparam logic [4:0] S_F8   = 5'd17;
    localparam logic [4:0] S_XMUL = 5'd18;
    localparam logic [4:0] S_R1   = 5'd19;
    localparam logic [4:0] S_R2   = 5'd20;
    localparam logic [4:0] S_R3   = 5'd21;
    localparam logic [4:0] S_OUT  = 5'd22;

    localparam logic [127:0] RC = {cmh_pkg::RC_HI, cmh_pkg::RC_LO};

    logic [4:0]        state_reg, state_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [127:0]      rh_reg, rh_next;
    logic [127:0]      cs_reg, cs_next;
    logic [63:0]       held_reg, held_next;
    logic [6:0]        pos_reg, pos_next;
    logic              full_reg, full_next;
    logic [3:0]        v_reg, v_next;
    logic              last_reg, last_next;
    logic              bnd_reg, bnd_next;
    logic              carry_reg, carry_next;
    logic [63:0]       opa_reg, opa_next;
    logic [63:0]       opb_reg, opb_next;
    logic [3:0][63:0]  acc_reg, acc_next;

    logic              mul_en;
    logic [31:0]       mul_a, mul_b;
    logic [2:0]        mul_col;
    logic              p_valid;
    logic [63:0]       p;
    logic [2:0]        p_col;

    logic [3:0]        v_eff;
    logic [63:0]       w_m;
    logic [2:0]        idx;
    logic [7:0]        pos_sum;
    logic [127:0]      cs_masked;
    logic [4:0]        after_abs;
    logic [127:0]      f2_sum;
    logic              f2_wrap;
    logic [64:0]       sum65;
    logic [127:0]      r_fold;
    logic [63:0]       hash_out;

    cmh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .col     (mul_col),
        .p_valid (p_valid),
        .p       (p),
        .p_col   (p_col)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cs_masked = {cs_reg[127:64] & cmh_pkg::SUM_MASK, cs_reg[63:0]};
    assign idx       = pos_reg[6:4];
    assign pos_sum   = 8'(pos_reg) + 8'(v_reg);
    assign f2_wrap   = (rh_reg[127:64] > cmh_pkg::P127_HI) ||
                       (rh_reg[127:64] == cmh_pkg::P127_HI && rh_reg[63:0] == '1);
    assign f2_sum    = rh_reg + 128'(f2_wrap);
    assign r_fold    = (128'(cs_reg[127:64]) << 8) + 128'(cs_reg[127:64]) +
                       128'(cs_reg[63:0]);
    assign hash_out  = cs_reg[63:0] +
                       ((cs_reg[63:0] > cmh_pkg::FOLD_LIMIT) ? cmh_pkg::FOLD : 64'd0);

    always_comb begin
        v_eff = (!item.last || item.valid_bytes > 4'd8) ? 4'd8 : item.valid_bytes;
        w_m   = item.data_word & cmh_pkg::byte_mask(v_eff);
    end

    // operand select for the shared multiplier
    always_comb begin
        mul_en  = 1'b0;
        mul_a   = opa_reg[31:0];
        mul_b   = opb_reg[31:0];
        mul_col = 3'(cnt_reg[1]) + 3'(cnt_reg[0]);
        if (state_reg == S_FMUL) begin
            mul_en  = (cnt_reg < 5'd16);
            mul_a   = rh_reg[32*cnt_reg[3:2] +: 32];
            mul_b   = RC[32*cnt_reg[1:0] +: 32];
            mul_col = 3'(cnt_reg[3:2]) + 3'(cnt_reg[1:0]);
        end else if (state_reg == S_PMUL || state_reg == S_XMUL) begin
            mul_en = (cnt_reg < 5'd4);
            mul_a  = cnt_reg[1] ? opa_reg[63:32] : opa_reg[31:0];
            mul_b  = cnt_reg[0] ? opb_reg[63:32] : opb_reg[31:0];
        end
    end

    always_comb begin
        after_abs = S_F1;
        if (bnd_reg) begin
            after_abs = last_reg ? S_F1 : S_IDLE;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rh_next    = rh_reg;
        cs_next    = cs_reg;
        held_next  = held_reg;
        pos_next   = pos_reg;
        full_next  = full_reg;
        v_next     = v_reg;
        last_next  = last_reg;
        bnd_next   = bnd_reg;
        carry_next = carry_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        acc_next   = acc_reg;
        sum65      = '0;
        res.valid  = 1'b0;
        res.hash   = hash_out;

        // product accumulation from the registered multiplier output
        if (p_valid) begin
            if (state_reg == S_FMUL) begin
                acc_next[p_col[1:0]] = acc_reg[p_col[1:0]] + (p_col[2] ? {p[62:0], 1'b0} : p);
            end else begin
                cs_next = cs_reg + (128'(p) << {p_col, 5'd0});
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    v_next    = v_eff;
                    last_next = item.last;
                    cnt_next  = '0;
                    if (!pos_reg[3]) begin
                        state_next = S_POS;
                        if (v_eff != 4'd0) begin
                            held_next = w_m;
                            if (item.last) begin
                                opa_next   = w_m + cmh_pkg::KTAB[{idx, 1'b0}];
                                opb_next   = cmh_pkg::KTAB[{idx, 1'b1}];
                                state_next = S_PMUL;
                            end
                        end
                    end else begin
                        opa_next   = held_reg + cmh_pkg::KTAB[{idx, 1'b0}];
                        opb_next   = w_m + cmh_pkg::KTAB[{idx, 1'b1}];
                        state_next = S_PMUL;
                    end
                end
            end
            S_PMUL: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    state_next = S_POS;
                end
            end
            S_POS: begin
                cnt_next = '0;
                acc_next = '0;
                bnd_next = 1'b0;
                if (pos_sum >= 8'd128) begin
                    bnd_next   = 1'b1;
                    state_next = full_reg ? S_FMUL : S_AADD;
                end else begin
                    pos_next = pos_sum[6:0];
                    if (!last_reg) begin
                        state_next = S_IDLE;
                    end else if (!full_reg || pos_sum != 8'd0) begin
                        state_next = full_reg ? S_FMUL : S_AADD;
                    end else begin
                        state_next = S_F1;
                    end
                end
            end
            S_AADD: begin
                rh_next    = cs_masked + RC;
                state_next = after_abs;
                if (bnd_reg) begin
                    full_next = 1'b1;
                    cs_next   = '0;
                    pos_next  = '0;
                end
            end
            S_FMUL: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16) begin
                    state_next = S_Q2;
                end
            end
            S_Q2: begin
                acc_next[2] = acc_reg[2] + cs_masked[127:64];
                state_next  = S_Q3;
            end
            S_Q3: begin
                acc_next[3] = acc_reg[3] + {32'd0, acc_reg[2][63:32]};
                state_next  = S_Q0;
            end
            S_Q0: begin
                acc_next[0] = acc_reg[0] + {32'd0, cs_reg[31:0]} + {31'd0, acc_reg[3][63:31]};
                state_next  = S_Q1;
            end
            S_Q1: begin
                acc_next[1] = acc_reg[1] + {32'd0, cs_reg[63:32]} + {32'd0, acc_reg[0][63:32]};
                state_next  = S_QWR;
            end
            S_QWR: begin
                rh_next[127:64] = {1'b0, acc_reg[3][30:0], acc_reg[2][31:0]} +
                                  {32'd0, acc_reg[1][63:32]};
                rh_next[63:0]   = {acc_reg[1][31:0], acc_reg[0][31:0]};
                state_next      = after_abs;
                if (bnd_reg) begin
                    full_next = 1'b1;
                    cs_next   = '0;
                    pos_next  = '0;
                end
            end
            S_F1: begin
                rh_next[127:64] = rh_reg[127:64] + {54'd0, pos_reg, 3'd0};
                state_next      = S_F2;
            end
            S_F2: begin
                rh_next    = {1'b0, f2_sum[126:0]};
                state_next = S_F3;
            end
            S_F3: begin
                acc_next[0] = rh_reg[127:64] + {32'd0, rh_reg[63:32]};
                state_next  = S_F4;
            end
            S_F4: begin
                acc_next[0] = acc_reg[0] + {32'd0, acc_reg[0][63:32]} + 64'd1;
                state_next  = S_F5;
            end
            S_F5: begin
                acc_next[0] = {32'd0, acc_reg[0][63:32]} + rh_reg[127:64];
                state_next  = S_F6;
            end
            S_F6: begin
                opb_next   = {acc_reg[0][31:0], 32'd0} + rh_reg[63:0];
                sum65      = 65'(acc_reg[0]) + 65'(cmh_pkg::FIN_A);
                opa_next   = sum65[63:0];
                carry_next = sum65[64];
                state_next = S_F7;
            end
            S_F7: begin
                if (carry_reg) begin
                    opa_next = opa_reg + cmh_pkg::FOLD;
                end
                sum65      = 65'(opb_reg) + 65'(cmh_pkg::FIN_B);
                opb_next   = sum65[63:0];
                carry_next = sum65[64];
                state_next = S_F8;
            end
            S_F8: begin
                if (carry_reg) begin
                    opb_next = opb_reg + cmh_pkg::FOLD;
                end
                cs_next    = '0;
                cnt_next   = '0;
                state_next = S_XMUL;
            end
            S_XMUL: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4) begin
                    state_next = S_R1;
                end
            end
            S_R1: begin
                cs_next    = r_fold;
                state_next = S_R2;
            end
            S_R2: begin
                cs_next    = r_fold;
                state_next = S_R3;
            end
            S_R3: begin
                if (cs_reg[127:64] != 64'd0) begin
                    cs_next = cs_reg + 128'(cmh_pkg::FOLD);
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                res.valid = 1'b1;
                if (out_free) begin
                    rh_next    = '0;
                    cs_next    = '0;
                    held_next  = '0;
                    pos_next   = '0;
                    full_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            rh_reg    <= '0;
            cs_reg    <= '0;
            held_reg  <= '0;
            pos_reg   <= '0;
            full_reg  <= 1'b0;
            last_reg  <= 1'b0;
            bnd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rh_reg    <= rh_next;
            cs_reg    <= cs_next;
            held_reg  <= held_next;
            pos_reg   <= pos_next;
            full_reg  <= full_next;
            last_reg  <= last_next;
            bnd_reg   <= bnd_next;
        end
        v_reg     <= v_next;
        carry_reg <= carry_next;
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        acc_reg   <= acc_next;
    end

endmodule

// File: src/chunked_mersenne_hash64.sv
// ----------------------------------------------------------------------------
// chunked_mersenne_hash64
// Streaming 64-bit message hash over 128-byte chunks, top level.
// ----------------------------------------------------------------------------
// One beat carries one little-endian message word; s_tlast marks the final
// word and only that beat yields a hash on the m_ side. All multiplication
// runs through a single 32x32 multiplier under a sequencer, and s_tready is
// low while a word is in work. The first word of a pair is held; the second
// (or a lone last word) issues four partial products plus a drain. Closing a
// 128-byte chunk adds an absorb step for the first chunk, or sixteen partial
// products and the carry steps for each later one. The last word further adds
// finalization, plus absorption of an open chunk if one remains. A finished
// hash waits in the output register while the next message is taken in.
module chunked_mersenne_hash64 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] data_word, [67:64] valid_bytes, zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] hash_value
);

    cmh_pkg::cmh_item_t item;
    cmh_pkg::cmh_res_t  res;
    logic               out_free;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [63:0]        m_tdata_reg, m_tdata_next;

    assign item.data_word   = s_tdata[63:0];
    assign item.valid_bytes = s_tdata[67:64];
    assign item.last        = s_tlast;
    assign out_free         = !m_tvalid_reg || m_tready;

    cmh_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .item     (item),
        .out_free (out_free),
        .res      (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res.valid && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = res.hash;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: src/cmh_checker.sv
// ----------------------------------------------------------------------------
// cmh_checker
// Port-level checks for the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module cmh_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before word finished");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while block was idle");

endmodule

bind chunked_mersenne_hash64 cmh_checker u_cmh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
